// ----- hdl/atkinson_dither_defines.svh -----
// Assertion macros used by the dither RTL.
`ifndef ATKINSON_DITHER_DEFINES_SVH
`define ATKINSON_DITHER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define ATK_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset
`define ATK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ATK_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ATK_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- hdl/atk_pkg.sv -----
`default_nettype none

package atk_pkg;

  // Pixel and quotient formats
  localparam int PIX_W     = 8;
  localparam int Q_W       = 5;

  // Line store geometry
  localparam int MAX_WIDTH = 512;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);

  typedef logic [PIX_W-1:0]         pix_t;
  typedef logic signed [Q_W-1:0]    quot_t;
  typedef logic [ADDR_W-1:0]        col_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // Line store access for one pixel step
  typedef struct packed {
    logic en;
    col_t waddr;
    col_t raddr_a;
    col_t raddr_b;
  } ls_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/atkinson_dither.sv -----
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------
//  pixel    | pixel_valid / pixel_stall  | pixel_in[7:0]
//  dot      | dot_valid / dot_stall      | dot_black, last_of_frame
//  config   | cfg_write_en               | cfg_index[0], cfg_data[15:0]
//
//  One pixel per clock while pixel_stall is low. Each item passes the
//  six-cell clamp chain and the threshold in the cycle it is taken; the
//  line store reads the next column's quotients at that same edge, so the
//  following item may enter in the next cycle.
//  Reset (rst) is synchronous; there is no clearing pass, line
//  stores hold stale data that the frame-edge gating ignores.
//  Results sit in a two-entry output queue; pixel_stall rises only when both
//  entries are full.
`default_nettype none
`include "atkinson_dither_defines.svh"

module atkinson_dither import atk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        pixel_valid,
  output logic        pixel_stall,
  input  logic [7:0]  pixel_in,
  output logic        dot_valid,
  input  logic        dot_stall,
  output logic        dot_black,
  output logic        last_of_frame
);

  localparam int WIDTH_W  = 10;
  localparam int HEIGHT_W = 16;
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 10'd360;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd1;

  // Configuration registers
  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_W-1:0];
      endcase
    end
  end

  // Effective frame size
  logic [ADDR_W:0]     w_eff;
  logic [HEIGHT_W-1:0] h_eff;

  always_comb begin
    if (image_width == '0) begin
      w_eff = (ADDR_W+1)'(1);
    end else if (WIDTH_W'(image_width) > WIDTH_W'(MAX_WIDTH)) begin
      w_eff = (ADDR_W+1)'(MAX_WIDTH);
    end else begin
      w_eff = image_width[ADDR_W:0];
    end
    h_eff = (image_height == '0) ? HEIGHT_W'(1) : image_height;
  end

  // Position and per-row quotient state
  col_t                column_count;
  logic [HEIGHT_W-1:0] row_count;
  quot_t               left_q;
  quot_t               left_two_q;
  quot_t               up_left_q;

  // Line store outputs: old upper[x], upper[x+1] and second[x]
  quot_t up_q;
  quot_t up_right_q;
  quot_t two_up_q;

  logic acc;
  logic [1:0] fill;
  logic pop;

  assign pixel_stall = (fill == 2'd2);
  assign acc         = pixel_valid && !pixel_stall;

  // Edge gating
  logic g_two, g_ul, g_up, g_ur, g_l2, g_l1;
  logic [ADDR_W:0] x_plus;

  assign x_plus = {1'b0, column_count} + (ADDR_W+1)'(1);
  assign g_two  = (row_count >= HEIGHT_W'(2));
  assign g_up   = (row_count != '0);
  assign g_ul   = g_up && (column_count != '0);
  assign g_ur   = g_up && (x_plus < w_eff);
  assign g_l2   = (column_count >= ADDR_W'(2));
  assign g_l1   = (column_count != '0);

  // Diffusion chain, in sender raster order
  pix_t v [7];
  assign v[0] = pixel_in;

  atk_cell u_cell_two (.v_in(v[0]), .q(two_up_q),   .gate(g_two), .v_out(v[1]));
  atk_cell u_cell_ul  (.v_in(v[1]), .q(up_left_q),  .gate(g_ul),  .v_out(v[2]));
  atk_cell u_cell_up  (.v_in(v[2]), .q(up_q),       .gate(g_up),  .v_out(v[3]));
  atk_cell u_cell_ur  (.v_in(v[3]), .q(up_right_q), .gate(g_ur),  .v_out(v[4]));
  atk_cell u_cell_l2  (.v_in(v[4]), .q(left_two_q), .gate(g_l2),  .v_out(v[5]));
  atk_cell u_cell_l1  (.v_in(v[5]), .q(left_q),     .gate(g_l1),  .v_out(v[6]));

  // Threshold and error quotient
  logic       black;
  pix_t       v_inv;
  logic [3:0] q_mag;
  quot_t      q_new;

  assign black = !v[6][PIX_W-1];
  assign v_inv = ~v[6];
  assign q_mag = black ? v[6][PIX_W-2:3] : v_inv[PIX_W-2:3];
  assign q_new = black ? quot_t'({1'b0, q_mag}) : -quot_t'({1'b0, q_mag});

  // Row and frame boundaries
  logic row_end, frame_end;
  col_t nx;

  assign row_end   = (x_plus >= w_eff);
  assign frame_end = row_end &&
                     (({1'b0, row_count} + (HEIGHT_W+1)'(1)) >= {1'b0, h_eff});
  assign nx        = row_end ? '0 : x_plus[ADDR_W-1:0];

  // Line stores: retire this pixel's quotient, fetch the next column
  ls_ctrl_t ls_ctrl;

  assign ls_ctrl.en      = acc;
  assign ls_ctrl.waddr   = column_count;
  assign ls_ctrl.raddr_a = nx;
  assign ls_ctrl.raddr_b = nx + ADDR_W'(1);

  atk_line_store u_line_store (
    .clk       (clk),
    .ctrl      (ls_ctrl),
    .wdata_up  (q_new),
    .wdata_two (up_q),
    .rd_a      (up_q),
    .rd_b      (up_right_q),
    .rd_two    (two_up_q)
  );

  // Position counters and left quotients
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      left_q       <= '0;
      left_two_q   <= '0;
    end else if (acc) begin
      column_count <= nx;
      if (row_end) begin
        row_count  <= frame_end ? '0 : row_count + HEIGHT_W'(1);
        left_q     <= '0;
        left_two_q <= '0;
      end else begin
        left_q     <= q_new;
        left_two_q <= left_q;
      end
    end
  end

  // Old upper[x] becomes upper-left for the next column
  always_ff @(posedge clk) begin
    if (acc) begin
      up_left_q <= up_q;
    end
  end

  // Two-entry output queue
  logic head_black, head_last, skid_black, skid_last;

  assign pop           = dot_valid && !dot_stall;
  assign dot_valid     = (fill != 2'd0);
  assign dot_black     = head_black;
  assign last_of_frame = head_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      fill <= fill + 2'(acc) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (acc && (fill == 2'd0 || (fill == 2'd1 && pop))) begin
      head_black <= black;
      head_last  <= frame_end;
    end else if (pop && fill == 2'd2) begin
      head_black <= skid_black;
      head_last  <= skid_last;
    end
    if (acc && fill == 2'd1 && !pop) begin
      skid_black <= black;
      skid_last  <= frame_end;
    end
  end

  // Checks
  `ATK_ASSERT_NEXT(a_frame_wrap, clk, rst, acc && frame_end,
                   (row_count == '0) && (column_count == '0),
                   "position not cleared after frame end")
  `ATK_ASSERT_NEXT(a_col_step, clk, rst, acc && !row_end,
                   column_count == ADDR_W'($past(column_count) + ADDR_W'(1)),
                   "column did not advance by one")
  `ATK_ASSERT_NEXT(a_row_left_clear, clk, rst, acc && row_end,
                   (left_q == '0) && (left_two_q == '0),
                   "left quotients kept across a row end")
  `ATK_ASSERT_IMPL(a_stall_full, clk, rst, pixel_stall,
                   dot_valid,
                   "input stalled with no result pending")
  `ATK_ASSERT_NEXT(a_fill_hold, clk, rst, !acc && !pop,
                   fill == $past(fill),
                   "queue fill changed without traffic")

endmodule

`default_nettype wire

// ----- hdl/atk_cell.sv -----
`default_nettype none

// One diffusion cell: adds a gated quotient to the running grey level and
// clamps the result to the pixel range.
module atk_cell import atk_pkg::*; (
  input  pix_t  v_in,
  input  quot_t q,
  input  logic  gate,
  output pix_t  v_out
);

  logic signed [PIX_W+1:0] sum;

  // Two guard bits catch both underflow and overflow
  assign sum = $signed({2'b00, v_in}) + (PIX_W+2)'(q);

  always_comb begin
    if (!gate) begin
      v_out = v_in;
    end else if (sum[PIX_W+1]) begin
      v_out = '0;
    end else if (sum[PIX_W]) begin
      v_out = '1;
    end else begin
      v_out = sum[PIX_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/atk_line_store.sv -----
`default_nettype none

// Quotient line stores: the row above and the row two above.
// One write and two reads on the upper row, one of each on the second row.
// Reads are registered; a read of the address being written returns the
// new data.
module atk_line_store import atk_pkg::*; (
  input  logic     clk,
  input  ls_ctrl_t ctrl,
  input  quot_t    wdata_up,
  input  quot_t    wdata_two,
  output quot_t    rd_a,
  output quot_t    rd_b,
  output quot_t    rd_two
);

  quot_t upper  [MAX_WIDTH];
  quot_t second [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      upper[ctrl.waddr]  <= wdata_up;
      second[ctrl.waddr] <= wdata_two;
      rd_a   <= (ctrl.raddr_a == ctrl.waddr) ? wdata_up  : upper[ctrl.raddr_a];
      rd_b   <= (ctrl.raddr_b == ctrl.waddr) ? wdata_up  : upper[ctrl.raddr_b];
      rd_two <= (ctrl.raddr_a == ctrl.waddr) ? wdata_two : second[ctrl.raddr_a];
    end
  end

endmodule

`default_nettype wire
